// ----- hdl/three_wire_serial_master_macros.svh -----
// assertion macros shared by the serial master checkers
`ifndef THREE_WIRE_SERIAL_MASTER_MACROS_SVH
`define THREE_WIRE_SERIAL_MASTER_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define TSM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked through reset as well
`define TSM_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tsm_pkg.sv -----
// shared types and constants of the three-wire serial master
`default_nettype none

package tsm_pkg;

   // bits in one shifted byte
   localparam int BITS_PER_BYTE = 8;
   localparam logic [2:0] BIT_LAST = 3'(BITS_PER_BYTE - 1);

   // ticks per pin phase after reset
   localparam logic [15:0] HALF_PERIOD_RESET = 16'd72;

   // classification of one input tick
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  address;
      logic [7:0]  write_data;
      logic        io_in;
   } tick_type;

   typedef struct packed {
      logic sclk;
      logic ce;
      logic io_out;
      logic io_drive;
   } pin_type;

   typedef struct packed {
      pin_type     pins;
      logic        ready_res;
      logic        done_res;
      logic [7:0]  read_data;
   } result_type;

endpackage

`default_nettype wire

// ----- hdl/three_wire_serial_master.sv -----
// top level of the three-wire serial master
//
// channel | prefix | handshake     | carries
// --------+--------+---------------+------------------------------------------
// request | req_   | valid / stall | one tick: start, command, bytes, data pin
// result  | rsp_   | valid / stall | pin levels, ready, done, read byte
// csr     | csr_   | valid / ready | half period in ticks (16 bits)
//
// one tick transfer is taken per cycle while the request queue has room; a
// two-entry queue sits before and after the phase sequencer; the sequencer
// updates its whole state per tick, which sets the rate
// synchronous active-high reset; half period resets to 72, no clearing pass
// a stalled result side fills the result queue and then stalls the request side
`default_nettype none

module three_wire_serial_master (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_start_req,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_address,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_io_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_sclk,
   output logic             rsp_ce,
   output logic             rsp_io_out,
   output logic             rsp_io_drive,
   output logic             rsp_ready_res,
   output logic             rsp_done_res,
   output logic [7:0]       rsp_read_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   tsm_pkg::tick_type   tick;
   tsm_pkg::result_type rsp;
   logic                tick_valid;
   logic                tick_stall;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // front end
   tsm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_req  (req_start_req),
      .req_command    (req_command),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_io_in      (req_io_in),
      .tick_valid     (tick_valid),
      .tick_stall     (tick_stall),
      .tick           (tick)
   );

   // phase sequencer
   tsm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .tick_valid (tick_valid),
      .tick_stall (tick_stall),
      .tick       (tick),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   // result fields
   assign rsp_sclk      = rsp.pins.sclk;
   assign rsp_ce        = rsp.pins.ce;
   assign rsp_io_out    = rsp.pins.io_out;
   assign rsp_io_drive  = rsp.pins.io_drive;
   assign rsp_ready_res = rsp.ready_res;
   assign rsp_done_res  = rsp.done_res;
   assign rsp_read_data = rsp.read_data;

endmodule

`default_nettype wire

// ----- hdl/tsm_queue.sv -----
// two-entry queue with valid / stall handshake on both sides
`default_nettype none

module tsm_queue #(
   parameter int WIDTH = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output logic [WIDTH-1:0]      out_data
);

   localparam logic [1:0] DEPTH = 2'd2;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push;
   logic             pop;

   // handshake flags
   assign in_stall  = (count_ff == DEPTH);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tsm_front.sv -----
// front end: takes request transfers, classifies them and queues them
`default_nettype none

module tsm_front (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_start_req,
   input  wire logic       req_command,
   input  wire logic [7:0] req_address,
   input  wire logic [7:0] req_write_data,
   input  wire logic       req_io_in,
   output logic            tick_valid,
   input  wire logic       tick_stall,
   output tsm_pkg::tick_type tick
);

   tsm_pkg::tick_type                   tick_in;
   logic [$bits(tsm_pkg::tick_type)-1:0] tick_data;

   // sort each tick into plain, write start or read start
   always_comb begin
      tick_in.address    = req_address;
      tick_in.write_data = req_write_data;
      tick_in.io_in      = req_io_in;
      if (!req_start_req) begin
         tick_in.kind = tsm_pkg::KIND_TICK;
      end else if (req_command) begin
         tick_in.kind = tsm_pkg::KIND_READ;
      end else begin
         tick_in.kind = tsm_pkg::KIND_WRITE;
      end
   end

   // queue towards the tick engine
   tsm_queue #(
      .WIDTH($bits(tsm_pkg::tick_type))
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (tick_in),
      .out_valid (tick_valid),
      .out_stall (tick_stall),
      .out_data  (tick_data)
   );

   assign tick = tsm_pkg::tick_type'(tick_data);

endmodule

`default_nettype wire

// ----- hdl/tsm_engine.sv -----
// back end: phase sequencer that drives the pins one tick per transfer
`default_nettype none

module tsm_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   input  wire logic [15:0] csr_data,
   input  wire logic        tick_valid,
   output logic             tick_stall,
   input  wire tsm_pkg::tick_type tick,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output tsm_pkg::result_type rsp
);

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_CE_LOW    = 4'd1,
      PH_CLK_LOW   = 4'd2,
      PH_CE_HIGH   = 4'd3,
      PH_ADDR_LOW  = 4'd4,
      PH_ADDR_HIGH = 4'd5,
      PH_TURN_LOW  = 4'd6,
      PH_DATA_LOW  = 4'd7,
      PH_DATA_HIGH = 4'd8,
      PH_RD_HIGH   = 4'd9,
      PH_RD_LOW    = 4'd10,
      PH_CE_OFF    = 4'd11,
      PH_PARK_HIGH = 4'd12,
      PH_IO_LOW    = 4'd13,
      PH_IO_HIGH   = 4'd14
   } phase_type;

   phase_type        phase_ff,     phase_in;
   logic [2:0]       bit_count_ff, bit_count_in;
   logic [7:0]       shift_ff,     shift_in;
   logic [7:0]       hold_ff,      hold_in;
   logic             is_read_ff,   is_read_in;
   logic [15:0]      timer_ff,     timer_in;
   logic [7:0]       captured_ff,  captured_in;
   tsm_pkg::pin_type pins_ff,      pins_in;
   logic [15:0]      half_period_ff;

   phase_type           next_phase;
   tsm_pkg::pin_type    pins_shown;
   tsm_pkg::result_type result;
   logic [15:0]         period;
   logic                ready_now;
   logic                done_now;
   logic                last_bit;
   logic                res_full;
   logic                fire;
   logic [$bits(tsm_pkg::result_type)-1:0] rsp_data;

   // pin levels set on entry to a phase
   function automatic tsm_pkg::pin_type enter_pins(
      input phase_type        p,
      input tsm_pkg::pin_type cur,
      input logic             lsb
   );
      tsm_pkg::pin_type nxt;
      nxt = cur;
      unique case (p)
         PH_CE_LOW:    nxt.ce = 1'b0;
         PH_CLK_LOW:   nxt.sclk = 1'b0;
         PH_CE_HIGH:   nxt.ce = 1'b1;
         PH_ADDR_LOW, PH_DATA_LOW: begin
            nxt.sclk     = 1'b0;
            nxt.io_drive = 1'b1;
            nxt.io_out   = lsb;
         end
         PH_ADDR_HIGH, PH_DATA_HIGH: nxt.sclk = 1'b1;
         PH_TURN_LOW:  nxt.sclk = 1'b0;
         PH_RD_HIGH: begin
            nxt.sclk     = 1'b1;
            nxt.io_drive = 1'b0;
         end
         PH_RD_LOW:    nxt.sclk = 1'b0;
         PH_CE_OFF:    nxt.ce = 1'b0;
         PH_PARK_HIGH: nxt.sclk = 1'b1;
         PH_IO_LOW: begin
            nxt.io_drive = 1'b1;
            nxt.io_out   = 1'b0;
         end
         PH_IO_HIGH:   nxt.io_out = 1'b1;
         default:      nxt = cur;
      endcase
      return nxt;
   endfunction

   // one tick is handled whenever the result queue has room
   assign fire       = tick_valid && !res_full;
   assign tick_stall = res_full;
   assign period     = (half_period_ff == 16'd0) ? 16'd1 : half_period_ff;
   assign ready_now  = (phase_ff == PH_IDLE);

   // tick update: optional start, then phase timer and phase change
   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      hold_in      = hold_ff;
      is_read_in   = is_read_ff;
      timer_in     = timer_ff;
      captured_in  = captured_ff;
      pins_in      = pins_ff;
      next_phase   = PH_IDLE;
      done_now     = 1'b0;
      last_bit     = (bit_count_ff == tsm_pkg::BIT_LAST);
      pins_shown   = pins_ff;

      if (fire) begin
         // start of a transaction only from idle
         if (ready_now && (tick.kind == tsm_pkg::KIND_WRITE ||
                           tick.kind == tsm_pkg::KIND_READ)) begin
            is_read_in   = (tick.kind == tsm_pkg::KIND_READ);
            shift_in     = tick.address;
            hold_in      = tick.write_data;
            bit_count_in = 3'd0;
            phase_in     = PH_CE_LOW;
            timer_in     = 16'd0;
            pins_in.ce   = 1'b0;
         end
         pins_shown = pins_in;
         last_bit   = (bit_count_in == tsm_pkg::BIT_LAST);

         if (phase_in != PH_IDLE) begin
            if (({1'b0, timer_in} + 17'd1) >= {1'b0, period}) begin
               // phase ends in this tick
               unique case (phase_in)
                  PH_CE_LOW:   next_phase = PH_CLK_LOW;
                  PH_CLK_LOW:  next_phase = PH_CE_HIGH;
                  PH_CE_HIGH:  next_phase = PH_ADDR_LOW;
                  PH_ADDR_LOW: next_phase = PH_ADDR_HIGH;
                  PH_ADDR_HIGH: begin
                     shift_in     = {1'b0, shift_in[7:1]};
                     bit_count_in = last_bit ? 3'd0 : bit_count_in + 3'd1;
                     next_phase   = last_bit ? PH_TURN_LOW : PH_ADDR_LOW;
                  end
                  PH_TURN_LOW: begin
                     if (is_read_in) begin
                        shift_in   = 8'd0;
                        next_phase = PH_RD_HIGH;
                     end else begin
                        shift_in   = hold_in;
                        next_phase = PH_DATA_LOW;
                     end
                  end
                  PH_DATA_LOW: next_phase = PH_DATA_HIGH;
                  PH_DATA_HIGH: begin
                     shift_in     = {1'b0, shift_in[7:1]};
                     bit_count_in = last_bit ? 3'd0 : bit_count_in + 3'd1;
                     next_phase   = last_bit ? PH_CE_OFF : PH_DATA_LOW;
                  end
                  PH_RD_HIGH: begin
                     shift_in   = {tick.io_in, shift_in[7:1]};
                     next_phase = PH_RD_LOW;
                  end
                  PH_RD_LOW: begin
                     bit_count_in = last_bit ? 3'd0 : bit_count_in + 3'd1;
                     next_phase   = last_bit ? PH_CE_OFF : PH_RD_HIGH;
                  end
                  PH_CE_OFF: begin
                     if (is_read_in) begin
                        next_phase = PH_PARK_HIGH;
                     end else begin
                        next_phase = PH_IDLE;
                        done_now   = 1'b1;
                     end
                  end
                  PH_PARK_HIGH: next_phase = PH_IO_LOW;
                  PH_IO_LOW:    next_phase = PH_IO_HIGH;
                  PH_IO_HIGH: begin
                     captured_in = shift_in;
                     next_phase  = PH_IDLE;
                     done_now    = 1'b1;
                  end
                  default:      next_phase = PH_IDLE;
               endcase
               timer_in = 16'd0;
               phase_in = next_phase;
               pins_in  = enter_pins(next_phase, pins_in, shift_in[0]);
            end else begin
               timer_in = timer_in + 16'd1;
            end
         end
      end

      result.pins      = pins_shown;
      result.ready_res = ready_now;
      result.done_res  = done_now;
      result.read_data = captured_in;
   end

   // sequencer state and period register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= 3'd0;
         shift_ff       <= 8'd0;
         hold_ff        <= 8'd0;
         is_read_ff     <= 1'b0;
         timer_ff       <= 16'd0;
         captured_ff    <= 8'd0;
         pins_ff        <= '{sclk: 1'b0, ce: 1'b0, io_out: 1'b0, io_drive: 1'b1};
         half_period_ff <= tsm_pkg::HALF_PERIOD_RESET;
      end else begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         hold_ff      <= hold_in;
         is_read_ff   <= is_read_in;
         timer_ff     <= timer_in;
         captured_ff  <= captured_in;
         pins_ff      <= pins_in;
         if (csr_valid) begin
            half_period_ff <= csr_data;
         end
      end
   end

   // result queue towards the response side
   tsm_queue #(
      .WIDTH($bits(tsm_pkg::result_type))
   ) u_res_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fire),
      .in_stall  (res_full),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp = tsm_pkg::result_type'(rsp_data);

endmodule

`default_nettype wire

// ----- hdl/tsm_checker.sv -----
// port-level checks of the serial master and their bind
`default_nettype none

`include "three_wire_serial_master_macros.svh"

module tsm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_ce,
   input wire logic        rsp_ready_res,
   input wire logic        rsp_done_res,
   input wire logic [7:0]  rsp_read_data
);

   // queues come out of reset empty
   `TSM_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid && !req_stall, "queues not empty after reset")

   // a completing transfer never started idle
   `TSM_ASSERT_SAME(a_done_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_ready_res, "done shown on an idle tick")

   // chip enable is low while idle and on completion
   `TSM_ASSERT_SAME(a_idle_ce_low, clock, reset, rsp_valid && (rsp_ready_res || rsp_done_res), !rsp_ce, "chip enable high while idle or done")

   // a stalled result stays valid with its read byte unchanged
   `TSM_ASSERT_SAME(a_rsp_hold, clock, reset, $past(rsp_valid && rsp_stall && !reset), rsp_valid && $stable(rsp_read_data), "stalled result changed")

endmodule

bind three_wire_serial_master tsm_checker u_tsm_checker (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the three-wire serial master: tick stimulus, pin-level prediction
`timescale 1ns / 100ps

module testbench;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;
   localparam int TICK_TARGET = 1600;
   localparam int DRAIN_CYCLES = 4;

   // predicts pin levels per tick and holds the results still to come
   class pin_scoreboard;
      typedef enum logic [3:0] {
         SEQ_IDLE, SEQ_CE_LOW, SEQ_CLK_LOW, SEQ_CE_HIGH, SEQ_ADDR_LOW,
         SEQ_ADDR_HIGH, SEQ_TURN_LOW, SEQ_DATA_LOW, SEQ_DATA_HIGH, SEQ_RD_HIGH,
         SEQ_RD_LOW, SEQ_CE_OFF, SEQ_PARK_HIGH, SEQ_IO_LOW, SEQ_IO_HIGH
      } seq_phase_type;

      logic [15:0]          half_period;
      seq_phase_type        seq_ph;
      logic [2:0]           bit_idx;
      logic [7:0]           shifter;
      logic [7:0]           held_data;
      logic                 read_op;
      logic [15:0]          timer;
      logic [7:0]           last_read;
      tsm_pkg::pin_type     pins;
      tsm_pkg::result_type  expected_q[$];
      int                   mismatches;
      int                   results_seen;

      function new();
         half_period = tsm_pkg::HALF_PERIOD_RESET;
         seq_ph = SEQ_IDLE;
         bit_idx = '0;
         shifter = '0;
         held_data = '0;
         read_op = 1'b0;
         timer = '0;
         last_read = '0;
         pins.sclk = 1'b0;
         pins.ce = 1'b0;
         pins.io_out = 1'b0;
         pins.io_drive = 1'b1;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void set_half_period(logic [15:0] value);
         half_period = value;
      endfunction

      function bit idle();
         return seq_ph == SEQ_IDLE;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // pin changes on entry to each phase
      function void enter(seq_phase_type next_ph);
         seq_ph = next_ph;
         timer = '0;
         case (next_ph)
            SEQ_CE_LOW:    pins.ce = 1'b0;
            SEQ_CLK_LOW:   pins.sclk = 1'b0;
            SEQ_CE_HIGH:   pins.ce = 1'b1;
            SEQ_ADDR_LOW, SEQ_DATA_LOW: begin
               pins.sclk = 1'b0;
               pins.io_drive = 1'b1;
               pins.io_out = shifter[0];
            end
            SEQ_ADDR_HIGH, SEQ_DATA_HIGH: pins.sclk = 1'b1;
            SEQ_TURN_LOW:  pins.sclk = 1'b0;
            SEQ_RD_HIGH: begin
               pins.sclk = 1'b1;
               pins.io_drive = 1'b0;
            end
            SEQ_RD_LOW:    pins.sclk = 1'b0;
            SEQ_CE_OFF:    pins.ce = 1'b0;
            SEQ_PARK_HIGH: pins.sclk = 1'b1;
            SEQ_IO_LOW: begin
               pins.io_drive = 1'b1;
               pins.io_out = 1'b0;
            end
            SEQ_IO_HIGH:   pins.io_out = 1'b1;
            default:       seq_ph = SEQ_IDLE;
         endcase
      endfunction

      // one bit finished, true once the byte is complete
      function bit byte_done();
         if (bit_idx >= tsm_pkg::BIT_LAST) begin
            bit_idx = '0;
            return 1'b1;
         end
         bit_idx = bit_idx + 3'd1;
         return 1'b0;
      endfunction

      // phase timer expired, true when the transaction completes
      function bit advance(logic io_level);
         bit fin;
         fin = 1'b0;
         case (seq_ph)
            SEQ_CE_LOW:   enter(SEQ_CLK_LOW);
            SEQ_CLK_LOW:  enter(SEQ_CE_HIGH);
            SEQ_CE_HIGH:  enter(SEQ_ADDR_LOW);
            SEQ_ADDR_LOW: enter(SEQ_ADDR_HIGH);
            SEQ_ADDR_HIGH: begin
               shifter = shifter >> 1;
               enter(byte_done() ? SEQ_TURN_LOW : SEQ_ADDR_LOW);
            end
            SEQ_TURN_LOW: begin
               if (read_op) begin
                  shifter = '0;
                  enter(SEQ_RD_HIGH);
               end else begin
                  shifter = held_data;
                  enter(SEQ_DATA_LOW);
               end
            end
            SEQ_DATA_LOW: enter(SEQ_DATA_HIGH);
            SEQ_DATA_HIGH: begin
               shifter = shifter >> 1;
               enter(byte_done() ? SEQ_CE_OFF : SEQ_DATA_LOW);
            end
            // sampled bit enters from the top
            SEQ_RD_HIGH: begin
               shifter = {io_level, shifter[7:1]};
               enter(SEQ_RD_LOW);
            end
            SEQ_RD_LOW: enter(byte_done() ? SEQ_CE_OFF : SEQ_RD_HIGH);
            SEQ_CE_OFF: begin
               if (!read_op) begin
                  seq_ph = SEQ_IDLE;
                  timer = '0;
                  fin = 1'b1;
               end else begin
                  enter(SEQ_PARK_HIGH);
               end
            end
            SEQ_PARK_HIGH: enter(SEQ_IO_LOW);
            SEQ_IO_LOW:    enter(SEQ_IO_HIGH);
            SEQ_IO_HIGH: begin
               last_read = shifter;
               seq_ph = SEQ_IDLE;
               timer = '0;
               fin = 1'b1;
            end
            default: begin
               seq_ph = SEQ_IDLE;
               timer = '0;
            end
         endcase
         return fin;
      endfunction

      // accepted tick: work out its result
      function void note_tick(logic start, logic cmd, logic [7:0] addr, logic [7:0] wdat,
                              logic io_level);
         int span;
         logic was_idle;
         tsm_pkg::result_type want;
         span = (half_period == 16'd0) ? 1 : int'(half_period);
         was_idle = (seq_ph == SEQ_IDLE);
         want.ready_res = was_idle;
         want.done_res = 1'b0;
         if (was_idle && start) begin
            read_op = cmd;
            shifter = addr;
            held_data = wdat;
            bit_idx = '0;
            enter(SEQ_CE_LOW);
         end
         want.pins = pins;
         if (seq_ph != SEQ_IDLE) begin
            if (int'(timer) + 1 >= span)
               want.done_res = advance(io_level);
            else
               timer = timer + 16'd1;
         end
         want.read_data = last_read;
         expected_q.push_back(want);
      endfunction

      task report(string what);
         mismatches++;
         $display("mismatch at result %0d: %s", results_seen, what);
      endtask

      // accepted result against the oldest expectation
      task check_result(tsm_pkg::result_type got);
         tsm_pkg::result_type want;
         if (expected_q.size() == 0) begin
            report("result transfer with nothing expected");
            return;
         end
         want = expected_q.pop_front();
         if (got.pins.sclk !== want.pins.sclk)
            report($sformatf("sclk %b, expected %b", got.pins.sclk, want.pins.sclk));
         if (got.pins.ce !== want.pins.ce)
            report($sformatf("ce %b, expected %b", got.pins.ce, want.pins.ce));
         if (got.pins.io_out !== want.pins.io_out)
            report($sformatf("io_out %b, expected %b", got.pins.io_out, want.pins.io_out));
         if (got.pins.io_drive !== want.pins.io_drive)
            report($sformatf("io_drive %b, expected %b", got.pins.io_drive,
                             want.pins.io_drive));
         if (got.ready_res !== want.ready_res)
            report($sformatf("ready_res %b, expected %b", got.ready_res, want.ready_res));
         if (got.done_res !== want.done_res)
            report($sformatf("done_res %b, expected %b", got.done_res, want.done_res));
         if (got.read_data !== want.read_data)
            report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
         results_seen++;
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_start_req = 1'b0;
   logic        req_command = CMD_WRITE;
   logic [7:0]  req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        req_io_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_sclk;
   logic        rsp_ce;
   logic        rsp_io_out;
   logic        rsp_io_drive;
   logic        rsp_ready_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   pin_scoreboard sb;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int ticks_sent = 0;

   three_wire_serial_master dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_req  (req_start_req),
      .req_command    (req_command),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_io_in      (req_io_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sclk       (rsp_sclk),
      .rsp_ce         (rsp_ce),
      .rsp_io_out     (rsp_io_out),
      .rsp_io_drive   (rsp_io_drive),
      .rsp_ready_res  (rsp_ready_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_data  (rsp_read_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one tick transfer, held until taken
   task automatic send_tick(input logic start, input logic cmd, input logic [7:0] addr,
                            input logic [7:0] wdat, input logic io_level);
      req_valid <= 1'b1;
      req_start_req <= start;
      req_command <= cmd;
      req_address <= addr;
      req_write_data <= wdat;
      req_io_in <= io_level;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_tick(start, cmd, addr, wdat, io_level);
      ticks_sent++;
   endtask

   // half period write, only while the pipeline is empty
   task automatic write_half_period(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_half_period(value);
      csr_valid <= 1'b0;
   endtask

   // hold off the sender until every result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic idle_gap();
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // result side: check each transfer, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0)
            sb.check_result(tsm_pkg::result_type'({rsp_sclk, rsp_ce, rsp_io_out,
                                                   rsp_io_drive, rsp_ready_res,
                                                   rsp_done_res, rsp_read_data}));
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   initial begin
      #(10_000_000);
      $display("status: fail");
      $finish;
   end

   initial begin
      int seg;
      int seg_len;
      int pick;
      logic [15:0] period;
      logic start;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset half period: idle tick with top field values, read start, starts while busy
      send_tick(1'b0, CMD_READ, 8'hFF, 8'hFF, 1'b1);
      send_tick(1'b1, CMD_READ, 8'hFF, 8'h00, 1'b0);
      send_tick(1'b1, CMD_WRITE, 8'h00, 8'hFF, 1'b1);
      send_tick(1'b1, CMD_WRITE, 8'h00, 8'h00, 1'b0);
      // largest half period mid-phase
      wait_drained();
      write_half_period(16'hFFFF);
      repeat (3) send_tick(1'b1, CMD_READ, 8'h5A, 8'hA5, 1'b1);
      // shrink below the running timer, phase ends at once
      wait_drained();
      write_half_period(16'd1);
      repeat (4) send_tick(1'b0, CMD_WRITE, 8'hFF, 8'hFF, 1'b0);
      // zero half period behaves as one tick per phase
      wait_drained();
      write_half_period(16'd0);
      for (int i = 0; i < 12; i++)
         send_tick(1'b1, i[0], 8'(i * 37), 8'(~i), i[1]);

      // random segments, each with its own half period and idling mix
      seg = 0;
      while (ticks_sent < TICK_TARGET) begin
         case (seg % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 80; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 80; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 30)
            period = 16'd0;
         else if (pick < 60)
            period = 16'd1;
         else if (pick < 80)
            period = 16'd2;
         else if (pick < 90)
            period = 16'd3;
         else if (pick < 96)
            period = 16'($urandom_range(4, 9));
         else if (pick < 98)
            period = tsm_pkg::HALF_PERIOD_RESET;
         else
            period = 16'hFFFF;
         wait_drained();
         write_half_period(period);
         seg_len = $urandom_range(40, 160);
         repeat (seg_len) begin
            idle_gap();
            // mostly start as soon as idle; starts while busy are noise
            if (sb.idle())
               start = ($urandom_range(0, 99) < 85);
            else
               start = ($urandom_range(0, 99) < 20);
            send_tick(start, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 299) == 0)
               wait_drained();
         end
         seg++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/tsm_pkg.sv
hdl/tsm_queue.sv
hdl/tsm_front.sv
hdl/tsm_engine.sv
hdl/three_wire_serial_master.sv
hdl/tsm_checker.sv
tb/sv/testbench.sv
